FILE: hw/rtl/framed_ascii_command_parser_unit_macros.svh
// Assertion macros for the framed ASCII command parser
// Depends on nothing; included by the top level only
`ifndef FRAMED_ASCII_COMMAND_PARSER_UNIT_MACROS_SVH
`define FRAMED_ASCII_COMMAND_PARSER_UNIT_MACROS_SVH

`ifndef SYNTH

// antecedent holds in a cycle, consequent holds in the same cycle
`define FCP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in a cycle, consequent holds in the next cycle
`define FCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FCP_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define FCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/fcp_pkg.sv
// Types, constants and decode helpers for the framed ASCII command parser
// Used by every module of the block; depends on nothing
package fcp_pkg;

    // payload buffer sizing
    localparam int MAX_PAYLOAD = 23;
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 2);
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);

    // framing characters
    localparam logic [7:0] OPEN_MARK  = 8'h5E;  // '^'
    localparam logic [7:0] CLOSE_MARK = 8'h24;  // '$'
    localparam logic [7:0] ASCII_ZERO = 8'h30;  // '0'
    localparam logic [7:0] ASCII_NINE = 8'h39;  // '9'

    // command letters
    localparam logic [7:0] CHAR_PING = 8'h70;   // 'p'
    localparam logic [7:0] CHAR_INFO = 8'h69;   // 'i'
    localparam logic [7:0] CHAR_SET  = 8'h73;   // 's'
    localparam logic [7:0] CHAR_MODE = 8'h6D;   // 'm'

    // frame lengths per command
    localparam int LEN_PING    = 4;
    localparam int LEN_INFO    = 4;
    localparam int LEN_SET     = 5;
    localparam int LEN_MODE    = 6;
    localparam int TIMESET_LEN = 23;
    localparam int MIN_LEN     = 2;

    // field positions inside the payload
    localparam int POS_HOUR    = 1;
    localparam int POS_MINUTE  = 4;
    localparam int POS_SECOND  = 7;
    localparam int POS_DAY     = 10;
    localparam int POS_MONTH   = 13;
    localparam int POS_CENTURY = 16;
    localparam int POS_YEAR    = 18;
    localparam int POS_WEEKDAY = 21;
    localparam int POS_SET_NUM = 3;
    localparam int POS_MODE_NUM = 4;

    typedef enum logic [2:0] {
        CMD_PING     = 3'd0,
        CMD_INFO     = 3'd1,
        CMD_SET      = 3'd2,
        CMD_MODE     = 3'd3,
        CMD_TIME_SET = 3'd4
    } command_t;

    typedef logic [MAX_PAYLOAD-1:0][7:0] payload_t;

    typedef struct packed {
        logic             in_frame;
        logic             close_hit;
        logic [LEN_W-1:0] length;
    } frame_status_t;

    typedef struct packed {
        command_t    command;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
        logic [6:0]  day_of_month;
        logic [6:0]  month;
        logic [13:0] full_year;
        logic [6:0]  weekday;
        logic [6:0]  number;
        logic        bad_digit;
    } result_t;

    typedef struct packed {
        logic       bad;
        logic [6:0] value;
    } pair_t;

    // byte of the payload at a fixed position, zero past the buffer
    function automatic logic [7:0] byte_at(payload_t p, int pos);
        logic [7:0] b;
        b = 8'h00;
        if (pos < MAX_PAYLOAD) begin
            b = p[pos];
        end
        return b;
    endfunction

    // two ASCII digits to a value; a non-digit reads as zero and flags
    function automatic pair_t pair_at(payload_t p, int pos);
        logic [7:0] hi_c;
        logic [7:0] lo_c;
        logic [3:0] hi_d;
        logic [3:0] lo_d;
        pair_t      r;
        hi_c  = byte_at(p, pos);
        lo_c  = byte_at(p, pos + 1);
        r.bad = 1'b0;
        hi_d  = 4'd0;
        lo_d  = 4'd0;
        if (hi_c < ASCII_ZERO || hi_c > ASCII_NINE) begin
            r.bad = 1'b1;
        end else begin
            hi_d = 4'(hi_c - ASCII_ZERO);
        end
        if (lo_c < ASCII_ZERO || lo_c > ASCII_NINE) begin
            r.bad = 1'b1;
        end else begin
            lo_d = 4'(lo_c - ASCII_ZERO);
        end
        r.value = 7'(hi_d) * 7'd10 + 7'(lo_d);
        return r;
    endfunction

endpackage

FILE: hw/rtl/framed_ascii_command_parser_unit.sv
// Top level of the framed ASCII command parser
// Depends on fcp_pkg, fcp_frame, fcp_decode, fcp_out_skid and the macros header
//
//  channel  ports            direction  carries
//  input    s_valid/s_ready  in         one received byte (s_rx_byte)
//  result   m_valid/m_ready  out        one decoded command and its fields
//
// One byte is taken per cycle while ready. A closing '$' puts its result
// in the output register, or in the one skid entry behind it if output stalls;
// input stops only when a result waits in both. aresetn is synchronous, active
// low, and leaves the block outside any frame with both output entries empty.
`include "framed_ascii_command_parser_unit_macros.svh"

module framed_ascii_command_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_command,
    output logic [6:0]  m_hour,
    output logic [6:0]  m_minute,
    output logic [6:0]  m_second,
    output logic [6:0]  m_day_of_month,
    output logic [6:0]  m_month,
    output logic [13:0] m_full_year,
    output logic [6:0]  m_weekday,
    output logic [6:0]  m_number,
    output logic        m_bad_digit
);
    import fcp_pkg::*;

    logic          accept;
    logic          hit;
    logic          push;
    frame_status_t status;
    payload_t      payload;
    result_t       decoded;
    result_t       out_data;

    assign accept = s_valid && s_ready;
    assign push   = status.close_hit && hit;

    // frame tracking and payload capture
    fcp_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .rx_byte (s_rx_byte),
        .status  (status),
        .payload (payload)
    );

    // classification and field decode from the buffered payload
    fcp_decode u_decode (
        .length  (status.length),
        .payload (payload),
        .hit     (hit),
        .result  (decoded)
    );

    // result register and skid entry
    fcp_out_skid u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_data  (decoded),
        .can_accept (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_data)
    );

    assign m_command      = out_data.command;
    assign m_hour         = out_data.hour;
    assign m_minute       = out_data.minute;
    assign m_second       = out_data.second;
    assign m_day_of_month = out_data.day_of_month;
    assign m_month        = out_data.month;
    assign m_full_year    = out_data.full_year;
    assign m_weekday      = out_data.weekday;
    assign m_number       = out_data.number;
    assign m_bad_digit    = out_data.bad_digit;

    // checks
    `FCP_ASSERT_IMPLIES(a_stall_needs_result, aclk, aresetn, !s_ready, m_valid, "input stalled with no result held")
    `FCP_ASSERT_NEXT(a_close_ends_frame, aclk, aresetn, push, !status.in_frame && status.length == '0, "frame still open after a result")
    `FCP_ASSERT_IMPLIES(a_push_length, aclk, aresetn, push, status.length == LEN_W'(LEN_PING) || status.length == LEN_W'(LEN_SET) || status.length == LEN_W'(LEN_MODE) || status.length == LEN_W'(TIMESET_LEN), "result from a frame of wrong length")
    `FCP_ASSERT_IMPLIES(a_short_cmd_clean, aclk, aresetn, m_valid && (m_command == CMD_PING || m_command == CMD_INFO), m_number == '0 && !m_bad_digit && m_full_year == '0, "ping or info result carries field data")

endmodule

FILE: hw/rtl/fcp_frame.sv
// Frame tracker: open/close detection, length counter and payload buffer
// Depends on fcp_pkg
module fcp_frame (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [7:0]            rx_byte,
    output fcp_pkg::frame_status_t status,
    output fcp_pkg::payload_t     payload
);
    import fcp_pkg::*;

    logic             in_frame_reg;
    logic             in_frame_next;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;
    payload_t         payload_store_reg;
    logic             close_hit;
    logic             store_en;

    // a close mark counts only after at least one payload byte
    assign close_hit = accept && in_frame_reg && (rx_byte == CLOSE_MARK)
                       && (length_reg != '0);

    // next frame state and length
    always_comb begin
        in_frame_next = in_frame_reg;
        length_next   = length_reg;
        store_en      = 1'b0;
        if (accept) begin
            if (!in_frame_reg) begin
                if (rx_byte == OPEN_MARK) begin
                    in_frame_next = 1'b1;
                    length_next   = '0;
                end
            end else if (close_hit) begin
                in_frame_next = 1'b0;
                length_next   = '0;
            end else if (length_reg < LEN_W'(MAX_PAYLOAD)) begin
                store_en    = 1'b1;
                length_next = length_reg + LEN_W'(1);
            end else begin
                length_next = LEN_W'(MAX_PAYLOAD + 1);
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            length_reg   <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            length_reg   <= length_next;
        end
    end

    // payload buffer, written at the current length
    always_ff @(posedge aclk) begin
        if (store_en) begin
            payload_store_reg[length_reg[IDX_W-1:0]] <= rx_byte;
        end
    end

    assign status.in_frame  = in_frame_reg;
    assign status.close_hit = close_hit;
    assign status.length    = length_reg;
    assign payload          = payload_store_reg;

endmodule

FILE: hw/rtl/fcp_decode.sv
// Command classifier and fixed-position two-digit field decode
// Depends on fcp_pkg
module fcp_decode (
    input  logic [fcp_pkg::LEN_W-1:0] length,
    input  fcp_pkg::payload_t         payload,
    output logic                      hit,
    output fcp_pkg::result_t          result
);
    import fcp_pkg::*;

    logic [7:0] first;
    logic       len_ok;
    pair_t      p_hour;
    pair_t      p_minute;
    pair_t      p_second;
    pair_t      p_day;
    pair_t      p_month;
    pair_t      p_century;
    pair_t      p_year;
    pair_t      p_weekday;
    pair_t      p_set;
    pair_t      p_mode;

    assign first  = payload[0];
    assign len_ok = (length >= LEN_W'(MIN_LEN)) && (length <= LEN_W'(MAX_PAYLOAD));

    // all candidate fields in parallel
    assign p_hour    = pair_at(payload, POS_HOUR);
    assign p_minute  = pair_at(payload, POS_MINUTE);
    assign p_second  = pair_at(payload, POS_SECOND);
    assign p_day     = pair_at(payload, POS_DAY);
    assign p_month   = pair_at(payload, POS_MONTH);
    assign p_century = pair_at(payload, POS_CENTURY);
    assign p_year    = pair_at(payload, POS_YEAR);
    assign p_weekday = pair_at(payload, POS_WEEKDAY);
    assign p_set     = pair_at(payload, POS_SET_NUM);
    assign p_mode    = pair_at(payload, POS_MODE_NUM);

    // classify by length, and by first letter for the short commands; unused fields stay zero
    always_comb begin
        hit    = 1'b0;
        result = '0;
        if (len_ok) begin
            if (length == LEN_W'(TIMESET_LEN)) begin
                hit                 = 1'b1;
                result.command      = CMD_TIME_SET;
                result.hour         = p_hour.value;
                result.minute       = p_minute.value;
                result.second       = p_second.value;
                result.day_of_month = p_day.value;
                result.month        = p_month.value;
                result.full_year    = 14'(p_century.value) * 14'd100
                                      + 14'(p_year.value);
                result.weekday      = p_weekday.value;
                result.bad_digit    = p_hour.bad | p_minute.bad | p_second.bad
                                      | p_day.bad | p_month.bad | p_century.bad
                                      | p_year.bad | p_weekday.bad;
            end else if (length == LEN_W'(LEN_PING) && first == CHAR_PING) begin
                hit            = 1'b1;
                result.command = CMD_PING;
            end else if (length == LEN_W'(LEN_INFO) && first == CHAR_INFO) begin
                hit            = 1'b1;
                result.command = CMD_INFO;
            end else if (length == LEN_W'(LEN_SET) && first == CHAR_SET) begin
                hit              = 1'b1;
                result.command   = CMD_SET;
                result.number    = p_set.value;
                result.bad_digit = p_set.bad;
            end else if (length == LEN_W'(LEN_MODE) && first == CHAR_MODE) begin
                hit              = 1'b1;
                result.command   = CMD_MODE;
                result.number    = p_mode.value;
                result.bad_digit = p_mode.bad;
            end
        end
    end

endmodule

FILE: hw/rtl/fcp_out_skid.sv
// Result register with a skid entry, so one more result is taken while output stalls
// Depends on fcp_pkg
module fcp_out_skid (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  fcp_pkg::result_t push_data,
    output logic             can_accept,
    output logic             out_valid,
    input  logic             out_ready,
    output fcp_pkg::result_t out_data
);
    import fcp_pkg::*;

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    main_free;

    // a push only happens while the skid entry is empty
    assign can_accept = !skid_valid_reg;
    assign main_free  = !main_valid_reg || out_ready;

    // refill the output register from skid first, then from a new push; a push that finds it busy goes to skid
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    // valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule
